// ----- rtl/rca_pkg.sv -----
package rca_pkg;

	// Frame geometry limits
	localparam int MAX_WIDTH   = 4096;
	localparam int MAX_HEIGHT  = 4096;
	localparam int SAMPLE_BITS = 16;

	// Field and register widths
	localparam int PIX_W    = 16;
	localparam int WIDE_W   = 13;
	localparam int NARROW_W = 12;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT) + 1;
	localparam int IDX_W    = 3;

	// Arithmetic widths
	localparam int SUM_W   = 40;
	localparam int FRAC_W  = 8;
	localparam int QUO_W   = SUM_W + FRAC_W;
	localparam int AREA_W  = 2 * WIDE_W;
	localparam int MEAN_W  = 24;
	localparam int STEP_W  = $clog2(QUO_W);
	localparam int LANES   = 3;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
	localparam logic [IDX_W-1:0] REG_RECT_LEFT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_RECT_TOP    = 3'd2;
	localparam logic [IDX_W-1:0] REG_RECT_RIGHT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_RECT_BOTTOM = 3'd4;

	// Lane indexes
	localparam int LANE_RED   = 0;
	localparam int LANE_GREEN = 1;
	localparam int LANE_BLUE  = 2;

	// Controls fanned out to every lane
	typedef struct packed {
		logic add;
		logic start;
		logic step;
	} lane_ctl_t;

	// Controls to the merge stage
	typedef struct packed {
		logic load;
		logic zero;
	} merge_ctl_t;

	typedef logic [LANES-1:0][PIX_W-1:0] lane_samples_t;
	typedef logic [LANES-1:0][QUO_W-1:0] lane_quos_t;

endpackage

// ----- rtl/rca_pixel_if.sv -----
interface rca_pixel_if;
	logic                     valid;
	logic                     ready;
	logic [rca_pkg::PIX_W-1:0] red;
	logic [rca_pkg::PIX_W-1:0] green;
	logic [rca_pkg::PIX_W-1:0] blue;
	logic                     frame_end;

	modport source (output valid, red, green, blue, frame_end, input ready);
	modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

// ----- rtl/rca_mean_if.sv -----
interface rca_mean_if;
	logic                      valid;
	logic                      ready;
	logic [rca_pkg::MEAN_W-1:0] mean_red;
	logic [rca_pkg::MEAN_W-1:0] mean_green;
	logic [rca_pkg::MEAN_W-1:0] mean_blue;

	modport source (output valid, mean_red, mean_green, mean_blue, input ready);
	modport sink   (input valid, mean_red, mean_green, mean_blue, output ready);
endinterface

// ----- rtl/rca_cfg_if.sv -----
interface rca_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [rca_pkg::IDX_W-1:0]  index;
	logic [rca_pkg::WIDE_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/rca_lane.sv -----
// One color channel: running sum plus a restoring divider, one quotient bit per step
module rca_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rca_pkg::lane_ctl_t         ctl,
	input  logic [rca_pkg::PIX_W-1:0]  sample,
	input  logic [rca_pkg::AREA_W-1:0] area,
	output logic [rca_pkg::QUO_W-1:0]  quo
);

	logic [rca_pkg::SUM_W-1:0]  sum_q;
	logic [rca_pkg::SUM_W-1:0]  sum_nx;
	logic [rca_pkg::AREA_W-1:0] rem_q;
	logic [rca_pkg::QUO_W-1:0]  quo_q;
	logic [rca_pkg::AREA_W:0]   trial;
	logic [rca_pkg::AREA_W:0]   diff;
	logic                       fits;

	// Sum including the current pixel when it lies inside
	always_comb begin
		sum_nx = sum_q;
		if (ctl.add) begin
			sum_nx = sum_q + rca_pkg::SUM_W'(sample[rca_pkg::SAMPLE_BITS-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.start) begin
			sum_q <= '0;
		end else if (ctl.add) begin
			sum_q <= sum_nx;
		end
	end

	// Divider trial subtract; dividend shifts out of quo_q as quotient shifts in
	assign trial = {rem_q, quo_q[rca_pkg::QUO_W-1]};
	assign diff  = trial - {1'b0, area};
	assign fits  = trial >= {1'b0, area};

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= {sum_nx, rca_pkg::FRAC_W'(0)};
			rem_q <= '0;
		end else if (ctl.step) begin
			rem_q <= fits ? diff[rca_pkg::AREA_W-1:0] : trial[rca_pkg::AREA_W-1:0];
			quo_q <= {quo_q[rca_pkg::QUO_W-2:0], fits};
		end
	end

	assign quo = quo_q;

endmodule

// ----- rtl/rca_ctrl.sv -----
// Config registers, raster position tracking, area and divider sequencing
module rca_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	rca_cfg_if.sink                     cfg,
	input  logic                        accept,
	input  logic                        frame_end,
	input  logic                        merge_free,
	output logic                        ready,
	output rca_pkg::lane_ctl_t          lane_ctl,
	output rca_pkg::merge_ctl_t         merge_ctl,
	output logic [rca_pkg::AREA_W-1:0]  area
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t                       state_q;
	logic [rca_pkg::STEP_W-1:0]   step_q;
	logic [rca_pkg::AREA_W-1:0]   area_q;
	logic                         zero_q;

	logic [rca_pkg::WIDE_W-1:0]   width_q;
	logic [rca_pkg::NARROW_W-1:0] left_q;
	logic [rca_pkg::NARROW_W-1:0] top_q;
	logic [rca_pkg::WIDE_W-1:0]   right_q;
	logic [rca_pkg::WIDE_W-1:0]   bottom_q;

	logic [rca_pkg::COL_W-1:0]    col_q;
	logic [rca_pkg::ROW_W-1:0]    row_q;

	logic [rca_pkg::WIDE_W-1:0]   width_eff;
	logic [rca_pkg::COL_W:0]      col_inc;
	logic                         row_open;
	logic                         in_rect;
	logic                         empty;
	logic [rca_pkg::WIDE_W-1:0]   dx;
	logic [rca_pkg::WIDE_W-1:0]   dy;
	logic [rca_pkg::AREA_W-1:0]   prod;

	// Config write port, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rca_pkg::WIDE_W'(rca_pkg::MAX_WIDTH);
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= rca_pkg::WIDE_W'(1);
			bottom_q <= rca_pkg::WIDE_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				rca_pkg::REG_IMAGE_WIDTH: width_q  <= cfg.data;
				rca_pkg::REG_RECT_LEFT:   left_q   <= cfg.data[rca_pkg::NARROW_W-1:0];
				rca_pkg::REG_RECT_TOP:    top_q    <= cfg.data[rca_pkg::NARROW_W-1:0];
				rca_pkg::REG_RECT_RIGHT:  right_q  <= cfg.data;
				rca_pkg::REG_RECT_BOTTOM: bottom_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Effective row length: zero acts as one, clamp to MAX_WIDTH
	always_comb begin
		width_eff = width_q;
		if (width_q == '0) begin
			width_eff = rca_pkg::WIDE_W'(1);
		end else if (width_q > rca_pkg::WIDE_W'(rca_pkg::MAX_WIDTH)) begin
			width_eff = rca_pkg::WIDE_W'(rca_pkg::MAX_WIDTH);
		end
	end

	assign col_inc  = {1'b0, col_q} + (rca_pkg::COL_W+1)'(1);
	assign row_open = row_q < rca_pkg::ROW_W'(rca_pkg::MAX_HEIGHT);
	assign in_rect  = row_open
	                  && (col_q >= left_q)
	                  && ({1'b0, col_q} < right_q)
	                  && (row_q >= {1'b0, top_q})
	                  && (row_q < bottom_q);

	// Position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (rca_pkg::WIDE_W'(col_inc) >= width_eff) begin
				col_q <= '0;
				if (row_open) begin
					row_q <= row_q + rca_pkg::ROW_W'(1);
				end
			end else begin
				col_q <= col_inc[rca_pkg::COL_W-1:0];
			end
		end
	end

	// Rectangle area, nominal and unclipped
	assign empty = (right_q <= {1'b0, left_q}) || (bottom_q <= {1'b0, top_q});
	assign dx    = right_q - {1'b0, left_q};
	assign dy    = bottom_q - {1'b0, top_q};
	assign prod  = rca_pkg::AREA_W'(dx) * rca_pkg::AREA_W'(dy);

	// Sequencer: idle takes pixels, divide runs one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			area_q  <= '0;
			zero_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && frame_end) begin
						state_q <= ST_DIV;
						step_q  <= '0;
						area_q  <= prod;
						zero_q  <= empty;
					end
				end
				ST_DIV: begin
					step_q <= step_q + rca_pkg::STEP_W'(1);
					if (step_q == rca_pkg::STEP_W'(rca_pkg::QUO_W-1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (merge_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign ready          = state_q == ST_IDLE;
	assign lane_ctl.add   = accept && in_rect;
	assign lane_ctl.start = accept && frame_end;
	assign lane_ctl.step  = state_q == ST_DIV;
	assign merge_ctl.load = (state_q == ST_FINISH) && merge_free;
	assign merge_ctl.zero = zero_q;
	assign area           = area_q;

endmodule

// ----- rtl/rca_merge.sv -----
// Collects the three lane quotients, saturates, and holds the result request
module rca_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rca_pkg::merge_ctl_t   ctl,
	input  rca_pkg::lane_quos_t   quos,
	output logic                  free,
	rca_mean_if.source            res
);

	logic                                         valid_q;
	logic [rca_pkg::LANES-1:0][rca_pkg::MEAN_W-1:0] mean_q;
	logic [rca_pkg::LANES-1:0][rca_pkg::MEAN_W-1:0] mean_nx;

	// Saturate to Q16.8 range; an empty rectangle gives zero
	always_comb begin
		for (int i = 0; i < rca_pkg::LANES; i++) begin
			if (ctl.zero) begin
				mean_nx[i] = '0;
			end else if (quos[i][rca_pkg::QUO_W-1:rca_pkg::MEAN_W] != '0) begin
				mean_nx[i] = '1;
			end else begin
				mean_nx[i] = quos[i][rca_pkg::MEAN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mean_q <= mean_nx;
		end
	end

	assign free           = !valid_q || res.ready;
	assign res.valid      = valid_q;
	assign res.mean_red   = mean_q[rca_pkg::LANE_RED];
	assign res.mean_green = mean_q[rca_pkg::LANE_GREEN];
	assign res.mean_blue  = mean_q[rca_pkg::LANE_BLUE];

endmodule

// ----- rtl/roi_color_average_top.sv -----
// Mean RGB over a rectangle of a raster-scanned frame.
// pix: pixel requests in raster order, one per cycle while ready is high;
//   frame_end marks the last pixel. Column and row are tracked internally.
// cfg: writes to index 0..4 (image_width, rect_left, rect_top, rect_right,
//   rect_bottom), always ready; user writes only between frames, unchecked.
// res: one request per frame carrying the three means, unsigned Q16.8,
//   sum * 256 / area truncated, saturated, zero for an empty rectangle.
// Throughput: one pixel per cycle inside a frame. After frame_end the three
//   lanes run a restoring divide at one quotient bit per cycle, then the
//   output register loads; pix.ready is low through the divide and the
//   load. The next frame may start while that result waits.
// Stall: if res is still held when the next frame's divide finishes,
//   pix.ready stays low until the output register frees up.
// Reset: sums and position clear, registers return to width 4096 and a
//   1x1 rectangle at the origin; no result is pending.
module roi_color_average_top (
	input  logic         clk,
	input  logic         arst_n,
	rca_pixel_if.sink    pix,
	rca_mean_if.source   res,
	rca_cfg_if.sink      cfg
);

	rca_pkg::lane_ctl_t           lane_ctl;
	rca_pkg::merge_ctl_t          merge_ctl;
	rca_pkg::lane_samples_t       samples;
	rca_pkg::lane_quos_t          quos;
	logic [rca_pkg::AREA_W-1:0]   area;
	logic                         accept;
	logic                         ready;
	logic                         merge_free;

	assign pix.ready = ready;
	assign accept    = pix.valid && ready;

	assign samples[rca_pkg::LANE_RED]   = pix.red;
	assign samples[rca_pkg::LANE_GREEN] = pix.green;
	assign samples[rca_pkg::LANE_BLUE]  = pix.blue;

	rca_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.accept     (accept),
		.frame_end  (pix.frame_end),
		.merge_free (merge_free),
		.ready      (ready),
		.lane_ctl   (lane_ctl),
		.merge_ctl  (merge_ctl),
		.area       (area)
	);

	// One lane per color channel
	for (genvar g = 0; g < rca_pkg::LANES; g++) begin : g_lane
		rca_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl),
			.sample (samples[g]),
			.area   (area),
			.quo    (quos[g])
		);
	end

	rca_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (merge_ctl),
		.quos   (quos),
		.free   (merge_free),
		.res    (res)
	);

endmodule

// ----- rtl/rca_checker.sv -----
module rca_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pix_valid,
	input logic                       pix_ready,
	input logic                       pix_frame_end,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [rca_pkg::MEAN_W-1:0] res_red,
	input logic                       cfg_ready
);

	logic [1:0] pending_q;
	logic       frame_acc;
	logic       res_acc;

	assign frame_acc = pix_valid && pix_ready && pix_frame_end;
	assign res_acc   = res_valid && res_ready;

	// Frames closed but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, frame_acc} - {1'b0, res_acc};
		end
	end

	// Held result request keeps its data
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_red))
		else $error("result changed while stalled");

	// Divide occupies the block right after a frame ends
	a_busy_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		frame_acc |=> !pix_ready)
		else $error("pixel accepted during divide");

	// No result without a closed frame
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != 2'd0)
		else $error("result without frame end");

	// At most one frame in divide plus one waiting at the output
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("too many frames outstanding");

	// Config port never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind roi_color_average_top rca_checker u_rca_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pix_valid     (pix.valid),
	.pix_ready     (pix.ready),
	.pix_frame_end (pix.frame_end),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_red       (res.mean_red),
	.cfg_ready     (cfg.ready)
);

// ----- sim/rca_mean_check.sv -----
module rca_mean_check
	import rca_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	rca_pixel_if pix,
	rca_mean_if  res,
	rca_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic [MEAN_W-1:0] red;
		logic [MEAN_W-1:0] green;
		logic [MEAN_W-1:0] blue;
	} mean_set_t;

	// Register copy
	logic [WIDE_W-1:0]   width_reg;
	logic [NARROW_W-1:0] left_reg;
	logic [NARROW_W-1:0] top_reg;
	logic [WIDE_W-1:0]   right_reg;
	logic [WIDE_W-1:0]   bottom_reg;

	// Raster position and channel sums
	logic [COL_W-1:0] column;
	logic [ROW_W-1:0] row;
	logic [SUM_W-1:0] acc [LANES];

	mean_set_t expected_means [$];
	int        mismatches = 0;
	int        outstanding = 0;

	assign fail_count = mismatches;
	assign pending    = outstanding;

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [MEAN_W-1:0] got,
			input logic [MEAN_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %06h, want %06h", name, got, want));
		end
	endtask

	// sum * 256 / area, truncated, saturated to 24 bits, zero for an empty area
	function automatic logic [MEAN_W-1:0] scaled_mean(input logic [SUM_W-1:0] total,
			input logic [AREA_W-1:0] area);
		logic [QUO_W-1:0] quo;
		if (area == '0) begin
			return '0;
		end
		quo = {total, {FRAC_W{1'b0}}} / QUO_W'(area);
		if (quo > QUO_W'({MEAN_W{1'b1}})) begin
			return '1;
		end
		return quo[MEAN_W-1:0];
	endfunction

	task automatic apply_write(input logic [IDX_W-1:0] idx, input logic [WIDE_W-1:0] value);
		case (idx)
		REG_IMAGE_WIDTH: width_reg  = value;
		REG_RECT_LEFT:   left_reg   = value[NARROW_W-1:0];
		REG_RECT_TOP:    top_reg    = value[NARROW_W-1:0];
		REG_RECT_RIGHT:  right_reg  = value;
		REG_RECT_BOTTOM: bottom_reg = value;
		default: ;
		endcase
	endtask

	// One pixel request: accumulate, advance position, close the frame on frame_end
	task automatic accumulate_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b, input logic last);
		logic [WIDE_W-1:0] eff_width;
		logic              in_rect;
		logic [AREA_W-1:0] area;
		mean_set_t         means;
		eff_width = width_reg;
		if (eff_width == '0) begin
			eff_width = WIDE_W'(1);
		end else if (eff_width > MAX_WIDTH) begin
			eff_width = WIDE_W'(MAX_WIDTH);
		end
		in_rect = row < MAX_HEIGHT && column >= left_reg && {1'b0, column} < right_reg &&
			row >= top_reg && row < bottom_reg;
		if (in_rect) begin
			acc[LANE_RED]   += SUM_W'(r[SAMPLE_BITS-1:0]);
			acc[LANE_GREEN] += SUM_W'(g[SAMPLE_BITS-1:0]);
			acc[LANE_BLUE]  += SUM_W'(b[SAMPLE_BITS-1:0]);
		end
		if ({1'b0, column} + 1'b1 >= eff_width) begin
			column = '0;
			if (row < MAX_HEIGHT) begin
				row++;
			end
		end else begin
			column++;
		end
		if (last) begin
			area = '0;
			if (right_reg > left_reg && bottom_reg > top_reg) begin
				area = (AREA_W'(right_reg) - AREA_W'(left_reg)) *
					(AREA_W'(bottom_reg) - AREA_W'(top_reg));
			end
			means.red   = scaled_mean(acc[LANE_RED], area);
			means.green = scaled_mean(acc[LANE_GREEN], area);
			means.blue  = scaled_mean(acc[LANE_BLUE], area);
			expected_means.push_back(means);
			column = '0;
			row    = '0;
			foreach (acc[i]) acc[i] = '0;
		end
	endtask

	// Watch all three channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		mean_set_t want;
		if (!arst_n) begin
			width_reg  = WIDE_W'(MAX_WIDTH);
			left_reg   = '0;
			top_reg    = '0;
			right_reg  = WIDE_W'(1);
			bottom_reg = WIDE_W'(1);
			column     = '0;
			row        = '0;
			foreach (acc[i]) acc[i] = '0;
			expected_means.delete();
		end else begin
			// a pixel on the same edge as a write still sees the old registers
			if (pix.valid && pix.ready) begin
				accumulate_pixel(pix.red, pix.green, pix.blue, pix.frame_end);
			end
			if (cfg.valid && cfg.ready) begin
				apply_write(cfg.index, cfg.data);
			end
			if (res.valid && res.ready) begin
				if (expected_means.size() == 0) begin
					report_mismatch($sformatf("result %06h %06h %06h with no frame pending",
						res.mean_red, res.mean_green, res.mean_blue));
				end else begin
					want = expected_means.pop_front();
					check_field("mean_red", res.mean_red, want.red);
					check_field("mean_green", res.mean_green, want.green);
					check_field("mean_blue", res.mean_blue, want.blue);
				end
			end
		end
		outstanding = expected_means.size();
	end

endmodule

// ----- sim/roi_color_average_top_test.sv -----
module roi_color_average_top_test;
	import rca_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 64;
	localparam int HOLD_CYCLES  = 500;
	localparam int RANDOM_ITEMS = 1750;
	// index with no register behind it, writes are dropped
	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   pix_idle_pct;
	int   res_stall_pct;
	int   hold_asked;

	rca_pixel_if pix_if ();
	rca_mean_if  res_if ();
	rca_cfg_if   cfg_if ();

	roi_color_average_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	rca_mean_check u_mean_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix_if),
		.res        (res_if),
		.cfg        (cfg_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [PIX_W-1:0] rand_sample();
		case ($urandom_range(7))
		0: return '0;
		1: return '1;
		default: return PIX_W'($urandom);
		endcase
	endfunction

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
		IDLE_NONE: begin
			pix_idle_pct  = 0;
			res_stall_pct = 0;
		end
		IDLE_SENDER: begin
			pix_idle_pct  = 54;
			res_stall_pct = 0;
		end
		IDLE_RECEIVER: begin
			pix_idle_pct  = 0;
			res_stall_pct = 54;
		end
		default: begin
			pix_idle_pct  = 36;
			res_stall_pct = 36;
		end
		endcase
	endtask

	// Called at a falling edge, returns at a falling edge
	task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = WIDE_W'(value);
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic set_region(input int w, input int l, input int t, input int r, input int b);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_RECT_LEFT, l);
		write_reg(REG_RECT_TOP, t);
		write_reg(REG_RECT_RIGHT, r);
		write_reg(REG_RECT_BOTTOM, b);
	endtask

	// Offer one pixel request, with random idle cycles ahead of it
	task automatic offer_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b, input logic last);
		while ($urandom_range(99) < pix_idle_pct) begin
			pix_if.valid = 1'b0;
			@(negedge clk);
		end
		pix_if.valid     = 1'b1;
		pix_if.red       = r;
		pix_if.green     = g;
		pix_if.blue      = b;
		pix_if.frame_end = last;
		do @(posedge clk); while (!pix_if.ready);
		@(negedge clk);
		if (last) begin
			pix_if.valid = 1'b0;
		end
	endtask

	task automatic send_frame(input int npix);
		for (int i = 0; i < npix; i++) begin
			offer_pixel(rand_sample(), rand_sample(), rand_sample(), i == npix - 1);
		end
	endtask

	// Drain all results, then let the divider finish any trailing work
	task automatic settle();
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Result receiver: random stalls plus a long hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		res_if.ready = 1'b0;
		hold_left    = 0;
		hold_seen    = 0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready = 1'b0;
			end else begin
				res_if.ready = ($urandom_range(99) >= res_stall_pct);
			end
		end
	end

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("roi_color_average_top regression: fail");
		$finish;
	end

	// Stimulus
	initial begin
		int phase;
		int regular;
		int w;
		int ew;
		int len;
		int left_hi;
		int top_hi;
		arst_n           = 1'b0;
		pix_if.valid     = 1'b0;
		pix_if.red       = '0;
		pix_if.green     = '0;
		pix_if.blue      = '0;
		pix_if.frame_end = 1'b0;
		cfg_if.valid     = 1'b0;
		cfg_if.index     = REG_IMAGE_WIDTH;
		cfg_if.data      = '0;
		hold_asked       = 0;
		set_idling(IDLE_NONE);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset geometry: only the origin pixel counts
		offer_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
		offer_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
		offer_pixel(16'h1234, 16'h5678, 16'h9ABC, 1'b1);
		// single-pixel frame at full scale
		offer_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		settle();

		// width 0 acts as 1; rectangle wider than the frame keeps its nominal area
		set_region(0, 0, 1, 3, 3);
		send_frame(4);
		settle();

		// zero-width rectangle, width above the maximum
		set_region(8191, 2, 0, 2, 1);
		send_frame(3);
		settle();

		// zero-height rectangle
		set_region(1, 0, 5, 4, 5);
		send_frame(2);
		settle();

		// write to an unused index, then a plain 2x2 frame
		write_reg(REG_SPARE, 13'h1FFF);
		set_region(2, 0, 0, 2, 2);
		send_frame(4);

		// Random phases
		phase   = 0;
		regular = 0;
		while (regular < RANDOM_ITEMS) begin
			settle();
			set_idling(idle_mode_t'(phase % 4));
			if (phase == 3) begin
				// full-width row: last column inside, wrap into the next row
				w = $urandom_range(1) ? MAX_WIDTH : $urandom_range(MAX_WIDTH + 1, 8191);
				set_region(w, MAX_WIDTH - 1, 0, MAX_WIDTH, 2);
				send_frame(MAX_WIDTH + $urandom_range(1, 20));
			end else if (phase == 6) begin
				// tall frame: rows past the maximum height must not be summed
				set_region($urandom_range(1), 0, 0, 1, MAX_HEIGHT + 4);
				send_frame(MAX_HEIGHT + $urandom_range(4, 40));
			end else if (phase == 9) begin
				// receiver holds off while frames keep coming, input must stall
				set_idling(IDLE_NONE);
				set_region(4, 1, 0, 3, 2);
				hold_asked++;
				repeat (8) begin
					len = $urandom_range(3, 10);
					send_frame(len);
					regular += len;
				end
			end else begin
				case ($urandom_range(9))
				0: w = 0;
				1: w = $urandom_range(13, 40);
				default: w = $urandom_range(1, 12);
				endcase
				ew = (w == 0) ? 1 : w;
				if ($urandom_range(7) == 0) begin
					set_region(w, MAX_WIDTH - 1, MAX_HEIGHT - 1, MAX_WIDTH, MAX_HEIGHT);
				end else begin
					// bit 12 of left/top lies beyond the register and is dropped
					left_hi = ($urandom_range(5) == 0) ? MAX_WIDTH : 0;
					top_hi  = ($urandom_range(5) == 0) ? MAX_WIDTH : 0;
					set_region(w, $urandom_range(0, ew + 1) + left_hi,
						$urandom_range(0, 4) + top_hi, $urandom_range(1, ew + 3),
						$urandom_range(1, 7));
				end
				repeat ($urandom_range(2, 5)) begin
					len = $urandom_range(1, 6) * ew;
					// partial last row now and then
					if ($urandom_range(3) == 0) begin
						len = $urandom_range(1, len + ew);
					end
					send_frame(len);
					regular += len;
				end
			end
			phase++;
		end

		settle();
		if (fail_count == 0) begin
			$display("roi_color_average_top regression: pass");
		end else begin
			$display("roi_color_average_top regression: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/rca_pkg.sv
rtl/rca_pixel_if.sv
rtl/rca_mean_if.sv
rtl/rca_cfg_if.sv
rtl/rca_lane.sv
rtl/rca_ctrl.sv
rtl/rca_merge.sv
rtl/roi_color_average_top.sv
rtl/rca_checker.sv
sim/rca_mean_check.sv
sim/roi_color_average_top_test.sv
